@@ hw/rtl/rsfm_pkg.sv @@
// ----------------------------------------------------------------------------
// rsfm_pkg
// Shared types and constants for the row span fill mask block.
// ----------------------------------------------------------------------------
package rsfm_pkg;

  localparam int CFG_W = 11;
  localparam int PIX_W = 8;
  localparam int RGB_W = 3 * PIX_W;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // fill color for the span
  localparam logic [PIX_W-1:0] PAINT_R = 8'd0;
  localparam logic [PIX_W-1:0] PAINT_G = 8'd0;
  localparam logic [PIX_W-1:0] PAINT_B = 8'd255;

  // pure green counts as both classes
  localparam logic [PIX_W-1:0] GREEN_R = 8'd0;
  localparam logic [PIX_W-1:0] GREEN_G = 8'd255;
  localparam logic [PIX_W-1:0] GREEN_B = 8'd0;

  typedef struct packed {
    logic emit;     // a held row pixel goes out with this item
    logic row_end;  // column is the last one of the row
  } emit_ctrl_t;

endpackage

@@ hw/rtl/rsfm_ifs.sv @@
// ----------------------------------------------------------------------------
// rsfm interfaces
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface rsfm_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rsfm_pkg::PIX_W-1:0]  red_in;
  logic [rsfm_pkg::PIX_W-1:0]  green_in;
  logic [rsfm_pkg::PIX_W-1:0]  blue_in;

  modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface rsfm_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic                        out_valid;
  logic [rsfm_pkg::PIX_W-1:0]  red_out;
  logic [rsfm_pkg::PIX_W-1:0]  green_out;
  logic [rsfm_pkg::PIX_W-1:0]  blue_out;
  logic                        row_end;

  modport source (output valid, out_valid, red_out, green_out, blue_out, row_end,
                  input ready);
  modport sink   (input valid, out_valid, red_out, green_out, blue_out, row_end,
                  output ready);
endinterface

interface rsfm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rsfm_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/rsfm_line_ram.sv @@
// ----------------------------------------------------------------------------
// rsfm_line_ram
// Single-port line buffer, read-first, registered read data.
// ----------------------------------------------------------------------------
module rsfm_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       re,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [rsfm_pkg::RGB_W-1:0] wdata,
  output logic [rsfm_pkg::RGB_W-1:0] rdata
);

  logic [rsfm_pkg::RGB_W-1:0] mem [DEPTH];

  // read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/rsfm_track.sv @@
// ----------------------------------------------------------------------------
// rsfm_track
// Column counter, row state and red/yellow span tracking; drives the line
// buffer write and the emit control for each accepted item.
// ----------------------------------------------------------------------------
module rsfm_track #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [rsfm_pkg::CFG_W-1:0] image_width,
  input  logic                       req_type,
  input  logic [rsfm_pkg::PIX_W-1:0] red_in,
  input  logic [rsfm_pkg::PIX_W-1:0] green_in,
  input  logic [rsfm_pkg::PIX_W-1:0] blue_in,
  output logic                       mem_we,
  output logic [CW-1:0]              col,
  output logic [rsfm_pkg::RGB_W-1:0] mem_wdata,
  output rsfm_pkg::emit_ctrl_t       ctrl,
  output logic [CW-1:0]              span_start,
  output logic [CW-1:0]              span_end
);

  localparam int LW = (CW + 1 > rsfm_pkg::CFG_W + 1) ? CW + 1 : rsfm_pkg::CFG_W + 1;

  logic          row_held, row_open;
  logic          red_seen, yel_seen;
  logic [CW-1:0] red_first, red_last, yel_first, yel_last;

  logic          row_held_next, row_open_next;
  logic          red_seen_next, yel_seen_next;
  logic [CW-1:0] red_first_next, red_last_next, yel_first_next, yel_last_next;
  logic [CW-1:0] span_start_next, span_end_next, col_next;

  logic [LW-1:0] wide_w, last;
  logic          drain, ignore, collecting, row_last;
  logic          is_green, is_red, is_yel;
  logic [rsfm_pkg::PIX_W-1:0] sr, sg, sb;
  logic [CW-1:0] rf, rl, yf, yl;

  // effective last column: zero width acts as one, oversize clamps
  always_comb begin
    wide_w = LW'(image_width);
    if (image_width == '0) begin
      last = '0;
    end else if (wide_w > LW'(MAX_WIDTH)) begin
      last = LW'(MAX_WIDTH - 1);
    end else begin
      last = wide_w - LW'(1);
    end
  end

  always_comb begin
    drain      = (req_type == rsfm_pkg::REQ_DRAIN);
    ignore     = drain && !row_open && !row_held;
    collecting = drain ? row_open : 1'b1;
    row_last   = (LW'(col) >= last);

    // drain slots pad with black
    sr = drain ? '0 : red_in;
    sg = drain ? '0 : green_in;
    sb = drain ? '0 : blue_in;

    is_green = (sr == rsfm_pkg::GREEN_R) && (sg == rsfm_pkg::GREEN_G) &&
               (sb == rsfm_pkg::GREEN_B);
    is_red   = ((sr != '0) && (sg == '0) && (sb == '0)) || is_green;
    is_yel   = ((sr != '0) && (sg != '0) && (sb == '0)) || is_green;

    red_seen_next  = red_seen;
    red_first_next = red_first;
    red_last_next  = red_last;
    yel_seen_next  = yel_seen;
    yel_first_next = yel_first;
    yel_last_next  = yel_last;
    if (collecting && is_red) begin
      if (!red_seen) red_first_next = col;
      red_last_next = col;
      red_seen_next = 1'b1;
    end
    if (collecting && is_yel) begin
      if (!yel_seen) yel_first_next = col;
      yel_last_next = col;
      yel_seen_next = 1'b1;
    end

    rf = red_seen_next ? red_first_next : '0;
    rl = red_seen_next ? red_last_next  : '0;
    yf = yel_seen_next ? yel_first_next : '0;
    yl = yel_seen_next ? yel_last_next  : '0;

    row_open_next   = drain ? row_open : 1'b1;
    row_held_next   = row_held;
    span_start_next = span_start;
    span_end_next   = span_end;
    col_next        = col + CW'(1);

    if (row_last) begin
      if (row_open_next) begin
        span_start_next = (rf > yf) ? rf : yf;
        span_end_next   = (yl > rl) ? rl : yl;
        row_held_next   = 1'b1;
        red_seen_next   = 1'b0;
        yel_seen_next   = 1'b0;
        red_first_next  = '0;
        red_last_next   = '0;
        yel_first_next  = '0;
        yel_last_next   = '0;
      end else begin
        row_held_next = 1'b0;
      end
      row_open_next = 1'b0;
      col_next      = '0;
    end
  end

  assign mem_we       = accept && !ignore && collecting;
  assign mem_wdata    = {sr, sg, sb};
  assign ctrl.emit    = row_held;
  assign ctrl.row_end = row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row_held   <= 1'b0;
      row_open   <= 1'b0;
      red_seen   <= 1'b0;
      yel_seen   <= 1'b0;
      red_first  <= '0;
      red_last   <= '0;
      yel_first  <= '0;
      yel_last   <= '0;
      span_start <= '0;
      span_end   <= '0;
    end else if (accept && !ignore) begin
      col        <= col_next;
      row_held   <= row_held_next;
      row_open   <= row_open_next;
      red_seen   <= red_seen_next;
      yel_seen   <= yel_seen_next;
      red_first  <= red_first_next;
      red_last   <= red_last_next;
      yel_first  <= yel_first_next;
      yel_last   <= yel_last_next;
      span_start <= span_start_next;
      span_end   <= span_end_next;
    end
  end

  // a closing row restarts the column count
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && !ignore && row_last |=> col == '0)
    else $error("column did not wrap at row end");

  // an ignored drain slot leaves the row state alone
  a_ignore_hold: assert property (@(posedge clk) disable iff (rst)
    accept && ignore |=> $stable(col) && !row_held && !row_open)
    else $error("ignored drain changed row state");

endmodule

@@ hw/rtl/rsfm_emit.sv @@
// ----------------------------------------------------------------------------
// rsfm_emit
// Holds the item while the line buffer read completes, applies the span
// fill and black-out, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module rsfm_emit #(
  parameter int CW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  output logic                         in_ready,
  input  rsfm_pkg::emit_ctrl_t         ctrl,
  input  logic [CW-1:0]                col,
  input  logic [CW-1:0]                span_start,
  input  logic [CW-1:0]                span_end,
  input  logic [rsfm_pkg::RGB_W-1:0]   rdata,
  rsfm_pix_out_if.source               pix_out
);

  logic                  s1_v, s1_adv, ov;
  rsfm_pkg::emit_ctrl_t  s1_ctrl;
  logic [CW-1:0]         s1_col, s1_start, s1_end;

  logic [rsfm_pkg::PIX_W-1:0] pr, pg, pb, nr, ng, nb;
  logic                       paint;

  assign s1_adv   = s1_v && (!ov || pix_out.ready);
  assign in_ready = !s1_v || s1_adv;

  always_comb begin
    pr = rdata[3*rsfm_pkg::PIX_W-1:2*rsfm_pkg::PIX_W];
    pg = rdata[2*rsfm_pkg::PIX_W-1:rsfm_pkg::PIX_W];
    pb = rdata[rsfm_pkg::PIX_W-1:0];
    paint = (s1_end > s1_start) && (s1_col >= s1_start) && (s1_col <= s1_end);
    nr = pr;
    ng = pg;
    nb = pb;
    if (!s1_ctrl.emit) begin
      nr = '0;
      ng = '0;
      nb = '0;
    end else if (paint) begin
      nr = rsfm_pkg::PAINT_R;
      ng = rsfm_pkg::PAINT_G;
      nb = rsfm_pkg::PAINT_B;
    end else if ((pb == '0) && ((pr != '0) || (pg != '0))) begin
      nr = '0;
      ng = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (in_ready) s1_v <= accept;
      if (s1_adv) begin
        ov <= 1'b1;
      end else if (pix_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl  <= ctrl;
      s1_col   <= col;
      s1_start <= span_start;
      s1_end   <= span_end;
    end
    if (s1_adv) begin
      pix_out.out_valid <= s1_ctrl.emit;
      pix_out.red_out   <= nr;
      pix_out.green_out <= ng;
      pix_out.blue_out  <= nb;
      pix_out.row_end   <= s1_ctrl.emit && s1_ctrl.row_end;
    end
  end

  assign pix_out.valid = ov;

  // a stalled item in the read stage stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_v && ov && !pix_out.ready |=> s1_v && $stable(s1_col))
    else $error("read stage lost a stalled item");

  // no new item may overwrite a stage that cannot move on
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!s1_v || !ov || pix_out.ready))
    else $error("item accepted into a blocked stage");

endmodule

@@ hw/rtl/row_span_fill_mask_top.sv @@
// ----------------------------------------------------------------------------
// row_span_fill_mask_top
// Row span fill mask: line-buffered red/yellow span fill to blue, one row
// of latency, drain items flush the held row.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the line RAM read stage, then the output stage.
// Throughput: 1 item per cycle while the output is not stalled; each item reads
//   the single-port line RAM and, unless it is a drain outside an open row,
//   writes it in the same cycle (read-first).
// Reset: clears the column, row and span state and the handshake stages; the
//   line RAM is not cleared. image_width resets to 1024.
// ----------------------------------------------------------------------------
module row_span_fill_mask_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic           clk,
  input  logic           rst,
  rsfm_cfg_if.sink       cfg,
  rsfm_pix_in_if.sink    pix_in,
  rsfm_pix_out_if.source pix_out
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [rsfm_pkg::CFG_W-1:0] image_width;
  logic                       accept, mem_we;
  logic [CW-1:0]              col, span_start, span_end;
  logic [rsfm_pkg::RGB_W-1:0] mem_wdata, mem_rdata;
  rsfm_pkg::emit_ctrl_t       ctrl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= rsfm_pkg::WIDTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      image_width <= cfg.data;
    end
  end

  assign accept = pix_in.valid && pix_in.ready;

  rsfm_track #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .image_width (image_width),
    .req_type    (pix_in.req_type),
    .red_in      (pix_in.red_in),
    .green_in    (pix_in.green_in),
    .blue_in     (pix_in.blue_in),
    .mem_we      (mem_we),
    .col         (col),
    .mem_wdata   (mem_wdata),
    .ctrl        (ctrl),
    .span_start  (span_start),
    .span_end    (span_end)
  );

  rsfm_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_ram (
    .clk   (clk),
    .re    (accept),
    .we    (mem_we),
    .addr  (col),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  rsfm_emit #(
    .CW (CW)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_ready   (pix_in.ready),
    .ctrl       (ctrl),
    .col        (col),
    .span_start (span_start),
    .span_end   (span_end),
    .rdata      (mem_rdata),
    .pix_out    (pix_out)
  );

endmodule
